FILE: src/assert_macros.svh
// Shared assertion helpers for the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/sfd_pkg.sv
package sfd_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  // Two payload banks, so at most two finished frames wait for replay.
  localparam int DESC_SLOTS = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_REPORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ACK    = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd85;
  localparam logic [7:0] SYNC_REPORT_RST = 8'd85;
  localparam logic [7:0] SYNC_ACK_RST    = 8'd175;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: src/sfd_ram.sv
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/sfd_front.sv
module sfd_front #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF,
  parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
  parameter int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int DESC_W      = LEN_W + 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          queue_full,
  output logic                          desc_push,
  output logic [DESC_W-1:0]             desc_data,
  output logic                          ram_wr_en,
  output logic [IDX_W:0]                ram_wr_addr,
  output logic [7:0]                    ram_wr_data
);
  import sfd_pkg::*;

  localparam logic [2:0] ST_HUNT  = 3'd0;
  localparam logic [2:0] ST_SYNC2 = 3'd1;
  localparam logic [2:0] ST_ID    = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;

  logic [7:0]       sync_first_r, sync_report_r, sync_ack_r;
  logic [2:0]       state_r, state_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [LEN_W-1:0] taken_r, taken_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       id_r, id_nxt;
  logic             ack_r, ack_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic [LEN_W-1:0] taken_inc;

  assign full      = queue_full;
  assign accept    = push && !queue_full;
  assign taken_inc = taken_r + LEN_W'(1);
  assign desc_data = {ack_r, id_r, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_report_r <= SYNC_REPORT_RST;
      sync_ack_r    <= SYNC_ACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        CFG_SYNC_REPORT: sync_report_r <= cfg_data;
        CFG_SYNC_ACK:    sync_ack_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    taken_nxt   = taken_r;
    len_nxt     = len_r;
    id_nxt      = id_r;
    ack_nxt     = ack_r;
    bank_nxt    = bank_r;
    desc_push   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = {bank_r, taken_r[IDX_W-1:0]};
    ram_wr_data = in_rx_byte;
    if (accept) begin
      case (state_r)
        ST_HUNT: begin
          if (in_rx_byte == sync_first_r) begin
            state_nxt = ST_SYNC2;
          end
          sum_nxt = in_rx_byte;
        end
        ST_SYNC2: begin
          if (in_rx_byte == sync_report_r || in_rx_byte == sync_ack_r) begin
            ack_nxt   = (in_rx_byte != sync_report_r);
            state_nxt = ST_ID;
          end else begin
            state_nxt = ST_HUNT;
          end
          sum_nxt = sum_r + in_rx_byte;
        end
        ST_ID: begin
          id_nxt    = in_rx_byte;
          state_nxt = ST_LEN;
          sum_nxt   = sum_r + in_rx_byte;
        end
        ST_LEN: begin
          if (in_rx_byte <= 8'(MAX_PAYLOAD)) begin
            len_nxt   = LEN_W'(in_rx_byte);
            taken_nxt = '0;
            state_nxt = (in_rx_byte != 8'd0) ? ST_DATA : ST_SUM;
            sum_nxt   = sum_r + in_rx_byte;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
        ST_DATA: begin
          ram_wr_en = (taken_r < LEN_W'(MAX_PAYLOAD));
          taken_nxt = taken_inc;
          sum_nxt   = sum_r + in_rx_byte;
          if (taken_inc >= len_r) begin
            state_nxt = ST_SUM;
          end
        end
        ST_SUM: begin
          // Good frame: hand it to replay and fill the other bank next.
          if (sum_r == in_rx_byte) begin
            desc_push = 1'b1;
            bank_nxt  = ~bank_r;
          end
          state_nxt = ST_HUNT;
        end
        default: state_nxt = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      sum_r   <= '0;
      taken_r <= '0;
      len_r   <= '0;
      id_r    <= '0;
      ack_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      taken_r <= taken_nxt;
      len_r   <= len_nxt;
      id_r    <= id_nxt;
      ack_r   <= ack_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

FILE: src/sfd_fifo.sv
`include "assert_macros.svh"

module sfd_fifo #(
  parameter int WIDTH = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic                rd_en,
  output logic [WIDTH-1:0]    rd_data,
  output sfd_pkg::fifo_stat_t stat
);
  import sfd_pkg::*;

  logic [WIDTH-1:0] slot_r [DESC_SLOTS];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'(DESC_SLOTS));
  assign stat.empty = (cnt_r == 2'd0);
  assign rd_data    = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `SFD_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_en, !stat.full)
  `SFD_ASSERT_IMP(a_no_underflow, clk, rst_n, rd_en, !stat.empty)
  `SFD_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 2'(DESC_SLOTS))

endmodule

FILE: src/sfd_back.sv
`include "assert_macros.svh"

module sfd_back #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF,
  parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
  parameter int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int DESC_W      = LEN_W + 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [DESC_W-1:0]   desc_data,
  input  sfd_pkg::fifo_stat_t queue_stat,
  output logic                desc_pop,
  output logic                ram_rd_en,
  output logic [IDX_W:0]      ram_rd_addr,
  input  logic [7:0]          ram_rd_data,
  output logic                empty,
  input  logic                pop,
  output logic                out_frame_kind,
  output logic [7:0]          out_message_id,
  output logic [5:0]          out_payload_length,
  output logic [7:0]          out_payload_byte,
  output logic [4:0]          out_byte_index,
  output logic                out_last
);
  import sfd_pkg::*;

  logic [LEN_W-1:0] d_len;
  logic [7:0]       d_id;
  logic             d_ack;
  logic             busy_r, busy_nxt;
  logic             rd_wait_r, rd_wait_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             bank_r, bank_nxt;
  logic             valid_r, valid_nxt;
  logic             pop_ok, load, is_last;
  logic             kind_r;
  logic [7:0]       id_r, byte_r;
  logic [5:0]       len_r;
  logic [4:0]       idx_r;
  logic             last_r;

  assign d_len   = desc_data[LEN_W-1:0];
  assign d_id    = desc_data[LEN_W+7:LEN_W];
  assign d_ack   = desc_data[LEN_W+8];
  assign pop_ok  = pop && valid_r;
  assign load    = rd_wait_r && (!valid_r || pop_ok);
  assign is_last = (d_len == '0) || ((LEN_W'(k_r) + LEN_W'(1)) == d_len);

  always_comb begin
    busy_nxt    = busy_r;
    rd_wait_nxt = rd_wait_r;
    k_nxt       = k_r;
    bank_nxt    = bank_r;
    valid_nxt   = valid_r;
    desc_pop    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = {bank_r, k_r};
    if (!busy_r && !queue_stat.empty) begin
      busy_nxt    = 1'b1;
      k_nxt       = '0;
      ram_rd_en   = 1'b1;
      ram_rd_addr = {bank_r, {IDX_W{1'b0}}};
      rd_wait_nxt = 1'b1;
    end
    if (load) begin
      valid_nxt = 1'b1;
      if (is_last) begin
        // Release the descriptor and its bank to the parser.
        busy_nxt    = 1'b0;
        rd_wait_nxt = 1'b0;
        desc_pop    = 1'b1;
        bank_nxt    = ~bank_r;
      end else begin
        k_nxt       = k_r + IDX_W'(1);
        ram_rd_en   = 1'b1;
        ram_rd_addr = {bank_r, k_r + IDX_W'(1)};
        rd_wait_nxt = 1'b1;
      end
    end else if (pop_ok) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= d_ack;
      id_r   <= d_id;
      len_r  <= 6'(d_len);
      byte_r <= (d_len == '0) ? 8'd0 : ram_rd_data;
      idx_r  <= 5'(k_r);
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rd_wait_r <= 1'b0;
      k_r       <= '0;
      bank_r    <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      rd_wait_r <= rd_wait_nxt;
      k_r       <= k_nxt;
      bank_r    <= bank_nxt;
      valid_r   <= valid_nxt;
    end
  end

  assign empty              = !valid_r;
  assign out_frame_kind     = kind_r;
  assign out_message_id     = id_r;
  assign out_payload_length = len_r;
  assign out_payload_byte   = byte_r;
  assign out_byte_index     = idx_r;
  assign out_last           = last_r;

  `SFD_ASSERT_IMP(a_busy_has_desc, clk, rst_n, busy_r, !queue_stat.empty)
  `SFD_ASSERT_IMP(a_wait_in_busy, clk, rst_n, rd_wait_r, busy_r)
  `SFD_ASSERT_NXT(a_last_frees, clk, rst_n, load && is_last, !busy_r && !rd_wait_r)

endmodule

FILE: src/sync_frame_deframer_sum8.sv
// Input: one byte per cycle unless full (two good frames held for replay).
// A good frame's descriptor is queued, then RAM reads feed the output register.
// Replay: one result per cycle while popped, set by the single RAM read port.
// Frames are double-buffered, so parsing runs on while the previous one replays.
// Reset (rst_n low, synchronous): parser hunts, queue and output are empty,
// sync registers return to 85, 85 and 175; the payload RAM is not cleared.
module sync_frame_deframer_sum8 #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_frame_kind,
  output logic [7:0]                    out_message_id,
  output logic [5:0]                    out_payload_length,
  output logic [7:0]                    out_payload_byte,
  output logic [4:0]                    out_byte_index,
  output logic                          out_last
);
  import sfd_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DESC_W = LEN_W + 9;

  fifo_stat_t        queue_stat;
  logic              desc_push, desc_pop;
  logic [DESC_W-1:0] desc_wr, desc_rd;
  logic              ram_wr_en, ram_rd_en;
  logic [IDX_W:0]    ram_wr_addr, ram_rd_addr;
  logic [7:0]        ram_wr_data, ram_rd_data;

  sfd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD), .LEN_W(LEN_W), .IDX_W(IDX_W), .DESC_W(DESC_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .queue_full (queue_stat.full),
    .desc_push  (desc_push),
    .desc_data  (desc_wr),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data)
  );

  sfd_fifo #(.WIDTH(DESC_W)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (desc_push),
    .wr_data(desc_wr),
    .rd_en  (desc_pop),
    .rd_data(desc_rd),
    .stat   (queue_stat)
  );

  sfd_ram #(.WIDTH(8), .DEPTH(2 ** (IDX_W + 1))) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  sfd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD), .LEN_W(LEN_W), .IDX_W(IDX_W), .DESC_W(DESC_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .desc_data         (desc_rd),
    .queue_stat        (queue_stat),
    .desc_pop          (desc_pop),
    .ram_rd_en         (ram_rd_en),
    .ram_rd_addr       (ram_rd_addr),
    .ram_rd_data       (ram_rd_data),
    .empty             (empty),
    .pop               (pop),
    .out_frame_kind    (out_frame_kind),
    .out_message_id    (out_message_id),
    .out_payload_length(out_payload_length),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_last          (out_last)
  );

endmodule
